>>> hdl/prewitt_horizontal_edge_rgb_unit_defines.svh
// Assertion macros for the horizontal edge unit.
`ifndef PREWITT_HORIZONTAL_EDGE_RGB_UNIT_DEFINES_SVH
`define PREWITT_HORIZONTAL_EDGE_RGB_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define PHE_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("phe: implication check failed");
`define PHE_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("phe: next-cycle check failed");
`else
`define PHE_ASSERT_IMP(label, clk, rstn, ante, cons)
`define PHE_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif
`endif

>>> hdl/phe_pkg.sv
package phe_pkg;

    localparam int CH_W     = 8;
    localparam int PIX_W    = 3 * CH_W;
    localparam int CFG_W    = 12;
    localparam int ROW_W    = CFG_W + 1;
    localparam int SUM_W    = CH_W + 2;
    localparam int PROD_W   = 2 * SUM_W;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd480;

    // floor(a/3) == (a*683) >> 11 for a <= 765
    localparam logic [SUM_W-1:0] DIV3_MUL   = 10'd683;
    localparam int               DIV3_SHIFT = 11;
    localparam logic [CH_W-1:0]  CH_MAX     = 8'd255;

    typedef enum logic [1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1
    } cfg_index_t;

    typedef struct packed {
        logic emit;
        logic interior;
        logic last;
        logic blank;
    } item_ctl_t;

endpackage

>>> hdl/phe_ram.sv
module phe_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write-first on a same-address collision
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rd_data_reg <= (we && (waddr == raddr)) ? wdata : mem[raddr];
        end
    end

    assign rdata = rd_data_reg;

endmodule

>>> hdl/phe_grad.sv
module phe_grad (
    input  logic [2:0][phe_pkg::CH_W-1:0] right,
    input  logic [2:0][phe_pkg::CH_W-1:0] left,
    output logic [phe_pkg::CH_W-1:0]      mag
);

    logic [phe_pkg::SUM_W-1:0]  right_sum;
    logic [phe_pkg::SUM_W-1:0]  left_sum;
    logic [phe_pkg::SUM_W-1:0]  diff;
    logic [phe_pkg::PROD_W-1:0] prod;
    logic [phe_pkg::CH_W:0]     quot;

    always_comb begin
        right_sum = phe_pkg::SUM_W'(right[0]) + phe_pkg::SUM_W'(right[1])
                  + phe_pkg::SUM_W'(right[2]);
        left_sum  = phe_pkg::SUM_W'(left[0]) + phe_pkg::SUM_W'(left[1])
                  + phe_pkg::SUM_W'(left[2]);
        diff = (right_sum >= left_sum) ? (right_sum - left_sum) : (left_sum - right_sum);
        prod = diff * phe_pkg::DIV3_MUL;
        quot = (phe_pkg::CH_W + 1)'(prod >> phe_pkg::DIV3_SHIFT);
        mag  = quot[phe_pkg::CH_W] ? phe_pkg::CH_MAX : quot[phe_pkg::CH_W-1:0];
    end

endmodule

>>> hdl/phe_ctrl.sv
module phe_ctrl #(
    parameter int MAX_LINE_PIXELS = 2048
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [1:0]                         cfg_index,
    input  logic [phe_pkg::CFG_W-1:0]          cfg_data,
    input  logic                               step,
    input  logic                               pad,
    output logic [$clog2(MAX_LINE_PIXELS)-1:0] pos_x,
    output phe_pkg::item_ctl_t                 ctl
);

    localparam int XW = $clog2(MAX_LINE_PIXELS);
    localparam int WW = XW + 1;
    localparam int YW = phe_pkg::ROW_W;

    logic [phe_pkg::CFG_W-1:0] width_reg, width_next;
    logic [phe_pkg::CFG_W-1:0] height_reg, height_next;
    logic [XW-1:0]             x_reg, x_next;
    logic [YW-1:0]             y_reg, y_next;
    logic [WW-1:0]             width_eff;
    logic [YW-1:0]             height_eff;
    logic                      x_last;

    always_comb begin
        if (width_reg == '0) begin
            width_eff = WW'(1);
        end else if (int'(width_reg) > MAX_LINE_PIXELS) begin
            width_eff = WW'(MAX_LINE_PIXELS);
        end else begin
            width_eff = WW'(width_reg);
        end
        height_eff = (height_reg == '0) ? YW'(1) : YW'(height_reg);
        x_last     = ((WW'(x_reg) + WW'(1)) == width_eff);

        ctl.emit     = (y_reg >= YW'(2)) || ((y_reg == YW'(1)) && (x_reg != '0));
        ctl.interior = (x_reg >= XW'(2)) && (y_reg >= YW'(2)) && (y_reg < height_eff);
        ctl.last     = (x_reg == '0) && (y_reg == (height_eff + YW'(1)));
        ctl.blank    = pad || (y_reg >= height_eff);
    end

    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        if (cfg_we) begin
            case (cfg_index)
                phe_pkg::CFG_IMAGE_WIDTH: begin
                    width_next = cfg_data;
                    x_next     = '0;
                    y_next     = '0;
                end
                phe_pkg::CFG_IMAGE_HEIGHT: begin
                    height_next = cfg_data;
                    x_next      = '0;
                    y_next      = '0;
                end
                default: begin
                end
            endcase
        end else if (step) begin
            if (ctl.last) begin
                x_next = '0;
                y_next = '0;
            end else if (x_last) begin
                x_next = '0;
                y_next = y_reg + YW'(1);
            end else begin
                x_next = x_reg + XW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= phe_pkg::WIDTH_RESET;
            height_reg <= phe_pkg::HEIGHT_RESET;
            x_reg      <= '0;
            y_reg      <= '0;
        end else begin
            width_reg  <= width_next;
            height_reg <= height_next;
            x_reg      <= x_next;
            y_reg      <= y_next;
        end
    end

    assign pos_x = x_reg;

endmodule

>>> hdl/prewitt_horizontal_edge_rgb_unit.sv
// channel  dir  handshake              payload
// s_       in   s_valid / s_ready      s_red_in s_green_in s_blue_in s_pad
// m_       out  m_valid / m_ready      m_red_out m_green_out m_blue_out m_last_of_frame
// cfg_     in   cfg_valid / cfg_ready  cfg_index cfg_data
//
// One word per cycle sustained unless m_ stalls; each word passes from s_ to m_ through the
// line-store read register, then output register; a pixel's result leaves W+1 words later.
// The line store is read and written once per word, which sets the one-per-cycle figure.
// Reset clears counters and valid flags and reloads the size registers, not the line store.
// cfg_ready is always high and a width or height write restarts the frame.
// A stalled m_ side holds both stages; s_ready drops only when both are full.
`include "prewitt_horizontal_edge_rgb_unit_defines.svh"

module prewitt_horizontal_edge_rgb_unit #(
    parameter int MAX_LINE_PIXELS = 2048
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [phe_pkg::CH_W-1:0]      s_red_in,
    input  logic [phe_pkg::CH_W-1:0]      s_green_in,
    input  logic [phe_pkg::CH_W-1:0]      s_blue_in,
    input  logic                          s_pad,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [phe_pkg::CH_W-1:0]      m_red_out,
    output logic [phe_pkg::CH_W-1:0]      m_green_out,
    output logic [phe_pkg::CH_W-1:0]      m_blue_out,
    output logic                          m_last_of_frame,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [1:0]                    cfg_index,
    input  logic [phe_pkg::CFG_W-1:0]     cfg_data
);

    localparam int XW = $clog2(MAX_LINE_PIXELS);
    localparam int PW = phe_pkg::PIX_W;
    localparam int CW = phe_pkg::CH_W;

    logic                  s_accept;
    logic                  s1_adv;
    logic [XW-1:0]         cur_x;
    phe_pkg::item_ctl_t    cur_ctl;

    logic                  s1_valid_reg, s1_valid_next;
    logic [PW-1:0]         s1_pix_reg;
    logic [XW-1:0]         s1_x_reg;
    phe_pkg::item_ctl_t    s1_ctl_reg;

    logic [2*PW-1:0]       ram_rdata;
    logic [2:0][PW-1:0]    new_col;
    logic [2:0][PW-1:0]    win_mid_reg;
    logic [2:0][PW-1:0]    win_right_reg;
    logic [2:0][CW-1:0]    grad_mag;
    logic [PW-1:0]         result_pix;

    logic                  m_valid_reg, m_valid_next;
    logic [PW-1:0]         m_pix_reg;
    logic                  m_last_reg;

    assign cfg_ready = 1'b1;
    assign s_accept  = s_valid && s_ready;
    assign s1_adv    = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !s1_valid_reg || s1_adv;

    phe_ctrl #(
        .MAX_LINE_PIXELS(MAX_LINE_PIXELS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_valid),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .step     (s_accept),
        .pad      (s_pad),
        .pos_x    (cur_x),
        .ctl      (cur_ctl)
    );

    // upper half: line above the lower one; lower half: previous line
    phe_ram #(
        .WIDTH(2 * PW),
        .DEPTH(MAX_LINE_PIXELS)
    ) u_line_store (
        .aclk (aclk),
        .we   (s1_adv),
        .waddr(s1_x_reg),
        .wdata({ram_rdata[PW-1:0], s1_pix_reg}),
        .re   (s_accept),
        .raddr(cur_x),
        .rdata(ram_rdata)
    );

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (s_accept) begin
            s1_valid_next = 1'b1;
        end else if (s1_adv) begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_pix_reg <= cur_ctl.blank ? '0 : {s_red_in, s_green_in, s_blue_in};
            s1_x_reg   <= cur_x;
            s1_ctl_reg <= cur_ctl;
        end
    end

    assign new_col[0] = ram_rdata[2*PW-1:PW];
    assign new_col[1] = ram_rdata[PW-1:0];
    assign new_col[2] = s1_pix_reg;

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            win_mid_reg   <= win_right_reg;
            win_right_reg <= new_col;
        end
    end

    for (genvar ch = 0; ch < 3; ch++) begin : g_chan
        localparam int HI = PW - 1 - ch * CW;
        logic [2:0][CW-1:0] right_px;
        logic [2:0][CW-1:0] left_px;
        for (genvar r = 0; r < 3; r++) begin : g_row
            assign right_px[r] = new_col[r][HI -: CW];
            assign left_px[r]  = win_mid_reg[r][HI -: CW];
        end
        phe_grad u_grad (
            .right(right_px),
            .left (left_px),
            .mag  (grad_mag[2-ch])
        );
    end

    assign result_pix = s1_ctl_reg.interior ? {grad_mag[2], grad_mag[1], grad_mag[0]}
                                            : win_right_reg[1];

    always_comb begin
        m_valid_next = m_valid_reg;
        if (s1_adv && s1_ctl_reg.emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv && s1_ctl_reg.emit) begin
            m_pix_reg  <= result_pix;
            m_last_reg <= s1_ctl_reg.last;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_red_out       = m_pix_reg[PW-1 -: CW];
    assign m_green_out     = m_pix_reg[PW-1-CW -: CW];
    assign m_blue_out      = m_pix_reg[CW-1:0];
    assign m_last_of_frame = m_last_reg;

    `PHE_ASSERT_NXT(a_frame_restart, aclk, aresetn, s_accept && cur_ctl.last, !cur_ctl.emit)
    `PHE_ASSERT_IMP(a_out_source, aclk, aresetn, $rose(m_valid_reg), $past(s1_adv && s1_ctl_reg.emit))
    `PHE_ASSERT_IMP(a_full_stall, aclk, aresetn, s1_valid_reg && m_valid_reg && !m_ready, !s_ready)

endmodule

>>> tb/tb_prewitt_horizontal_edge_rgb_unit.sv
module tb_prewitt_horizontal_edge_rgb_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_MAX      = 2048;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int SETTLE_CYCLES = 12;
    localparam int LONG_STALL    = 400;
    localparam int PHASE_QUOTA   = 150;
    localparam int PART_WORDS    = 24;
    localparam int SMALL_FRAME   = 64;
    localparam logic [1:0] CFG_SPARE_A = 2'd2;
    localparam logic [1:0] CFG_SPARE_B = 2'd3;

    typedef struct packed {
        logic [phe_pkg::CH_W-1:0] red;
        logic [phe_pkg::CH_W-1:0] green;
        logic [phe_pkg::CH_W-1:0] blue;
        logic                     pad;
    } raster_word_t;

    typedef struct packed {
        logic [phe_pkg::CH_W-1:0] red;
        logic [phe_pkg::CH_W-1:0] green;
        logic [phe_pkg::CH_W-1:0] blue;
        logic                     last;
    } edge_pixel_t;

    logic                      aclk       = 1'b0;
    logic                      aresetn    = 1'b0;
    logic                      s_valid    = 1'b0;
    logic                      s_ready;
    logic [phe_pkg::CH_W-1:0]  s_red_in   = '0;
    logic [phe_pkg::CH_W-1:0]  s_green_in = '0;
    logic [phe_pkg::CH_W-1:0]  s_blue_in  = '0;
    logic                      s_pad      = 1'b0;
    logic                      m_valid;
    logic                      m_ready    = 1'b0;
    logic [phe_pkg::CH_W-1:0]  m_red_out;
    logic [phe_pkg::CH_W-1:0]  m_green_out;
    logic [phe_pkg::CH_W-1:0]  m_blue_out;
    logic                      m_last_of_frame;
    logic                      cfg_valid  = 1'b0;
    logic                      cfg_ready;
    logic [1:0]                cfg_index  = phe_pkg::CFG_IMAGE_WIDTH;
    logic [phe_pkg::CFG_W-1:0] cfg_data   = '0;

    prewitt_horizontal_edge_rgb_unit #(
        .MAX_LINE_PIXELS(LINE_MAX)
    ) uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_red_in        (s_red_in),
        .s_green_in      (s_green_in),
        .s_blue_in       (s_blue_in),
        .s_pad           (s_pad),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_red_out       (m_red_out),
        .m_green_out     (m_green_out),
        .m_blue_out      (m_blue_out),
        .m_last_of_frame (m_last_of_frame),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    // filter state as seen from outside
    logic [phe_pkg::PIX_W-1:0] upper_line [LINE_MAX];
    logic [phe_pkg::PIX_W-1:0] lower_line [LINE_MAX];
    logic [phe_pkg::PIX_W-1:0] win_px [9];
    int                        col_pos;
    int                        row_pos;
    int                        out_pos;
    logic [phe_pkg::CFG_W-1:0] width_reg  = phe_pkg::WIDTH_RESET;
    logic [phe_pkg::CFG_W-1:0] height_reg = phe_pkg::HEIGHT_RESET;

    raster_word_t raster_words [$];
    edge_pixel_t  edge_pixels [$];
    raster_word_t next_word;

    int  words_sent    = 0;
    int  mismatches    = 0;
    int  cycle_count   = 0;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  rx_force      = 1'b0;
    bit  stall_kick    = 1'b0;
    bit  stall_seen    = 1'b0;
    int  stall_left    = 0;
    bit  in_taken      = 1'b0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic int eff_width();
        if (width_reg == 0) return 1;
        if (width_reg > LINE_MAX) return LINE_MAX;
        return int'(width_reg);
    endfunction

    function automatic int eff_height();
        return (height_reg == 0) ? 1 : int'(height_reg);
    endfunction

    task automatic restart_count();
        col_pos = 0;
        row_pos = 0;
        out_pos = 0;
        foreach (win_px[i]) win_px[i] = '0;
    endtask

    task automatic apply_reg(input logic [1:0] idx, input logic [phe_pkg::CFG_W-1:0] val);
        if (idx == phe_pkg::CFG_IMAGE_WIDTH) begin
            width_reg = val;
            restart_count();
        end else if (idx == phe_pkg::CFG_IMAGE_HEIGHT) begin
            height_reg = val;
            restart_count();
        end
    endtask

    function automatic logic [phe_pkg::CH_W-1:0] channel_grad(input int sh);
        int acc;
        int a;
        int b;
        int k;
        acc = 0;
        for (k = 0; k < 3; k++) begin
            a = int'(win_px[k*3+2][sh +: phe_pkg::CH_W]);
            b = int'(win_px[k*3][sh +: phe_pkg::CH_W]);
            acc += a - b;
        end
        acc = (acc < 0) ? -acc : acc;
        acc = acc / 3;
        if (acc > int'(phe_pkg::CH_MAX)) acc = int'(phe_pkg::CH_MAX);
        return acc[phe_pkg::CH_W-1:0];
    endfunction

    task automatic prewitt_step(input logic [phe_pkg::CH_W-1:0] r,
                                input logic [phe_pkg::CH_W-1:0] g,
                                input logic [phe_pkg::CH_W-1:0] b, input logic pad);
        int                        w;
        int                        h;
        int                        x;
        int                        y;
        int                        rr;
        int                        cc;
        int                        k;
        logic [phe_pkg::PIX_W-1:0] pix;
        logic [phe_pkg::PIX_W-1:0] up;
        logic [phe_pkg::PIX_W-1:0] lo;
        logic [phe_pkg::PIX_W-1:0] centre;
        logic [phe_pkg::PIX_W-1:0] outpix;
        edge_pixel_t               res;
        w = eff_width();
        h = eff_height();
        x = col_pos;
        y = row_pos;
        pix = (pad || (y * w + x >= w * h)) ? '0 : {r, g, b};
        up = upper_line[x];
        lo = lower_line[x];
        centre = (x == 0) ? upper_line[w-1] : upper_line[x-1];
        for (k = 0; k < 3; k++) begin
            win_px[k*3]   = win_px[k*3+1];
            win_px[k*3+1] = win_px[k*3+2];
        end
        win_px[2] = up;
        win_px[5] = lo;
        win_px[8] = pix;
        upper_line[x] = lo;
        lower_line[x] = pix;
        if (x + 1 >= w) begin
            col_pos = 0;
            row_pos = y + 1;
        end else begin
            col_pos = x + 1;
        end
        if (!(y >= 2 || (y == 1 && x >= 1))) return;
        if (x == 0) begin
            rr = y - 2;
            cc = w - 1;
        end else begin
            rr = y - 1;
            cc = x - 1;
        end
        if (rr >= 1 && rr + 2 <= h && cc >= 1 && cc + 2 <= w)
            outpix = {channel_grad(16), channel_grad(8), channel_grad(0)};
        else
            outpix = centre;
        res.red   = outpix[23:16];
        res.green = outpix[15:8];
        res.blue  = outpix[7:0];
        if (out_pos + 1 >= w * h) begin
            res.last = 1'b1;
            restart_count();
        end else begin
            res.last = 1'b0;
            out_pos++;
        end
        edge_pixels.push_back(res);
    endtask

    // sender
    always @(negedge aclk) begin
        if (!s_valid || in_taken) begin
            if (raster_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                next_word = raster_words.pop_front();
                s_red_in   <= next_word.red;
                s_green_in <= next_word.green;
                s_blue_in  <= next_word.blue;
                s_pad      <= next_word.pad;
                s_valid    <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver, with its own long hold-off count
    always @(negedge aclk) begin
        if (stall_kick != stall_seen) begin
            stall_seen = stall_kick;
            stall_left = LONG_STALL;
        end
        if (rx_force) begin
            m_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        in_taken <= s_valid && s_ready;
        if (aresetn && s_valid && s_ready)
            prewitt_step(s_red_in, s_green_in, s_blue_in, s_pad);
    end

    always @(posedge aclk) begin
        edge_pixel_t want;
        if (aresetn && m_valid && m_ready) begin
            if (edge_pixels.size() == 0) begin
                $error("output word with nothing outstanding");
                mismatches++;
            end else begin
                want = edge_pixels.pop_front();
                if (m_red_out !== want.red) begin
                    $error("red_out: expected %0d, got %0d", want.red, m_red_out);
                    mismatches++;
                end
                if (m_green_out !== want.green) begin
                    $error("green_out: expected %0d, got %0d", want.green, m_green_out);
                    mismatches++;
                end
                if (m_blue_out !== want.blue) begin
                    $error("blue_out: expected %0d, got %0d", want.blue, m_blue_out);
                    mismatches++;
                end
                if (m_last_of_frame !== want.last) begin
                    $error("last_of_frame: expected %0d, got %0d", want.last,
                           m_last_of_frame);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic settle();
        while (raster_words.size() != 0 || s_valid) @(posedge aclk);
        while (edge_pixels.size() != 0) @(posedge aclk);
        rx_force = 1'b1;
        repeat (SETTLE_CYCLES) @(posedge aclk);
        rx_force = 1'b0;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [phe_pkg::CFG_W-1:0] val);
        settle();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        apply_reg(idx, val);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_geometry(input int w, input int h);
        write_reg(phe_pkg::CFG_IMAGE_WIDTH, w[phe_pkg::CFG_W-1:0]);
        write_reg(phe_pkg::CFG_IMAGE_HEIGHT, h[phe_pkg::CFG_W-1:0]);
    endtask

    task automatic push_word(input logic [phe_pkg::CH_W-1:0] r,
                             input logic [phe_pkg::CH_W-1:0] g,
                             input logic [phe_pkg::CH_W-1:0] b, input logic pad);
        raster_words.push_back(raster_word_t'{red: r, green: g, blue: b, pad: pad});
        words_sent++;
    endtask

    task automatic push_random(input logic pad);
        push_word(phe_pkg::CH_W'($urandom_range(255)), phe_pkg::CH_W'($urandom_range(255)),
                  phe_pkg::CH_W'($urandom_range(255)), pad);
    endtask

    // one whole frame plus its flush words
    task automatic queue_frame(input bit pause_mid);
        int n;
        int w;
        int i;
        w = eff_width();
        n = w * eff_height();
        for (i = 0; i < n; i++) begin
            if (pause_mid && i == n / 2) settle();
            push_random($urandom_range(99) < 4);
        end
        for (i = 0; i <= w; i++)
            push_random($urandom_range(99) < 80);
    endtask

    // start of a large frame, abandoned by the next register write
    task automatic queue_partial(input int n);
        repeat (n) push_random(1'b0);
    endtask

    task automatic queue_noise();
        int n;
        n = $urandom_range(1, 2 * eff_width());
        repeat (n) push_random(1'($urandom_range(1)));
    endtask

    task automatic run_phase(input int s_pct, input int r_pct, input int quota);
        int target;
        int w;
        int h;
        int frames;
        bit first;
        @(posedge aclk);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        target = words_sent + quota;
        first = 1'b1;
        while (words_sent < target) begin
            w = ($urandom_range(9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 12);
            h = ($urandom_range(9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 7);
            set_geometry(w, h);
            frames = $urandom_range(1, 3);
            repeat (frames) begin
                queue_frame(first || $urandom_range(7) == 0);
                first = 1'b0;
            end
            if ($urandom_range(3) == 0) queue_noise();
        end
    endtask

    initial begin
        int ext_w [6];
        int ext_h [6];
        ext_w = '{0, 1, 4095, 2048, 3, 1};
        ext_h = '{0, 1, 1, 3, 4095, 4095};
        foreach (upper_line[i]) upper_line[i] = '0;
        foreach (lower_line[i]) lower_line[i] = '0;
        restart_count();

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        send_idle_pct = 26;
        recv_idle_pct = 65;

        // 3x3: full-scale gradients of both signs, pad inside the frame,
        // non-pad words in the flush
        set_geometry(3, 3);
        push_word(8'hFF, 8'h00, 8'hFF, 1'b0);
        push_word(8'h5A, 8'hA5, 8'h3C, 1'b0);
        push_word(8'h00, 8'hFF, 8'h7F, 1'b0);
        push_word(8'hFF, 8'h00, 8'hFF, 1'b0);
        push_word(8'hFF, 8'hFF, 8'hFF, 1'b1);
        push_word(8'h00, 8'hFF, 8'h7F, 1'b0);
        push_word(8'hFF, 8'h00, 8'hFF, 1'b0);
        push_word(8'h00, 8'h00, 8'h00, 1'b0);
        push_word(8'h00, 8'hFF, 8'h7F, 1'b0);
        push_word(8'h00, 8'h00, 8'h00, 1'b1);
        push_word(8'hFF, 8'hFF, 8'hFF, 1'b0);
        push_word(8'hAA, 8'h55, 8'hAA, 1'b1);
        push_word(8'hFF, 8'hFF, 8'hFF, 1'b0);

        // 2x2 pass-through; spare index mid-frame leaves it running
        set_geometry(2, 2);
        push_word(8'h01, 8'h80, 8'hFE, 1'b0);
        push_word(8'hFE, 8'h7F, 8'h01, 1'b0);
        write_reg(CFG_SPARE_A, '1);
        push_random(1'b0);
        push_random(1'b0);
        repeat (3) push_random(1'b1);

        // abandoned frame: a real write mid-frame restarts the counters
        push_random(1'b0);
        push_random(1'b0);
        write_reg(phe_pkg::CFG_IMAGE_HEIGHT, 12'd2);
        write_reg(CFG_SPARE_B, '0);
        repeat (4) push_random(1'b0);
        repeat (3) push_random(1'b1);

        run_phase(26, 65, PHASE_QUOTA);
        run_phase(65, 26, PHASE_QUOTA);
        run_phase(0, 0, PHASE_QUOTA);

        // long receiver hold-off against a steady sender
        set_geometry(12, 8);
        @(posedge aclk);
        stall_kick = ~stall_kick;
        queue_frame(1'b0);

        foreach (ext_w[i]) begin
            set_geometry(ext_w[i], ext_h[i]);
            if (eff_width() * eff_height() <= SMALL_FRAME)
                queue_frame(1'b0);
            else
                queue_partial(PART_WORDS);
        end

        settle();
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
